@@ sv/vmc_pkg.sv @@
// Package with payload types and widths for the 2D vector length clamp.
`default_nettype none
package vmc_pkg;
    localparam int DataWidth = 16;
    localparam int LenWidth  = DataWidth - 1;
    localparam int MagWidth  = DataWidth;          // magnitude of a component
    localparam int SqWidth   = 2 * MagWidth + 1;   // x*x + y*y
    localparam int RootWidth = MagWidth + 1;       // ceil(sqrt) fits here
    localparam int ProdWidth = MagWidth + LenWidth;

    typedef struct packed {
        logic signed [DataWidth-1:0] vec_x;
        logic signed [DataWidth-1:0] vec_y;
    } t_vec_in;

    typedef struct packed {
        logic signed [DataWidth-1:0] out_x;
        logic signed [DataWidth-1:0] out_y;
        logic                        clamped;
    } t_vec_out;

    // Side data that travels with an item through the root and divide stages.
    typedef struct packed {
        logic                 neg_x;
        logic                 neg_y;
        logic [MagWidth-1:0]  mag_x;
        logic [MagWidth-1:0]  mag_y;
        logic [LenWidth-1:0]  limit;
        logic                 clamp;
        t_vec_in              raw;
    } t_side;
endpackage
`default_nettype wire

@@ sv/vmc_sqrt.sv @@
// Pipelined ceiling square root, one result bit per stage.
`default_nettype none
module vmc_sqrt (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [vmc_pkg::SqWidth-1:0]       i_sq,
    input  wire vmc_pkg::t_side                    i_side,
    output logic                                   o_valid,
    output logic [vmc_pkg::RootWidth-1:0]          o_root,
    output vmc_pkg::t_side                         o_side
);
    localparam int Steps = vmc_pkg::RootWidth;
    localparam int RemW  = vmc_pkg::SqWidth + 2;

    logic                           r_vld  [Steps+1];
    logic [vmc_pkg::SqWidth-1:0]    r_rad  [Steps+1];
    logic [RemW-1:0]                r_rem  [Steps+1];
    logic [vmc_pkg::RootWidth-1:0]  r_q    [Steps+1];
    vmc_pkg::t_side                 r_side [Steps+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_rad[0]  = i_sq;
        r_rem[0]  = '0;
        r_q[0]    = '0;
        r_side[0] = i_side;
    end

    // Restoring square root: step k brings in radicand bit pair Steps-1-k.
    // The top pair reaches past the radicand, so its upper bit reads as zero.
    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [RemW-1:0] n_trial;
        logic [RemW-1:0] n_rem;
        logic [1:0]      n_pair;
        always_comb begin
            n_pair  = 2'(r_rad[k] >> (2*(Steps-1-k)));
            n_rem   = {r_rem[k][RemW-3:0], n_pair};
            n_trial = {{(RemW-vmc_pkg::RootWidth-2){1'b0}}, r_q[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_rad[k+1]  <= r_rad[k];
                r_side[k+1] <= r_side[k];
                if (n_rem >= n_trial) begin
                    r_rem[k+1] <= n_rem - n_trial;
                    r_q[k+1]   <= {r_q[k][vmc_pkg::RootWidth-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_rem;
                    r_q[k+1]   <= {r_q[k][vmc_pkg::RootWidth-2:0], 1'b0};
                end
            end
        end
    end

    // A nonzero remainder means the radicand is not a perfect square: round up.
    assign o_valid = r_vld[Steps];
    assign o_root  = r_q[Steps] + vmc_pkg::RootWidth'(r_rem[Steps] != '0);
    assign o_side  = r_side[Steps];
endmodule
`default_nettype wire

@@ sv/vmc_div.sv @@
// Pipelined restoring divider: two quotients of one shared divisor, one bit per stage.
`default_nettype none
module vmc_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [vmc_pkg::ProdWidth-1:0]     i_num_x,
    input  wire logic [vmc_pkg::ProdWidth-1:0]     i_num_y,
    input  wire logic [vmc_pkg::RootWidth-1:0]     i_den,
    input  wire vmc_pkg::t_side                    i_side,
    output logic                                   o_valid,
    output logic [vmc_pkg::MagWidth-1:0]           o_quo_x,
    output logic [vmc_pkg::MagWidth-1:0]           o_quo_y,
    output vmc_pkg::t_side                         o_side
);
    // The quotient is at most the magnitude, so MagWidth bits suffice.
    localparam int Steps = vmc_pkg::MagWidth;
    localparam int NW    = vmc_pkg::ProdWidth;
    localparam int RW    = vmc_pkg::RootWidth + 1;

    logic                          r_vld  [Steps+1];
    logic [NW-1:0]                 r_nx   [Steps+1];
    logic [NW-1:0]                 r_ny   [Steps+1];
    logic [RW-1:0]                 r_rx   [Steps+1];
    logic [RW-1:0]                 r_ry   [Steps+1];
    logic [vmc_pkg::RootWidth-1:0] r_den  [Steps+1];
    vmc_pkg::t_side                r_side [Steps+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_nx[0]   = i_num_x;
        r_ny[0]   = i_num_y;
        r_rx[0]   = '0;
        r_ry[0]   = '0;
        r_den[0]  = i_den;
        r_side[0] = i_side;
    end

    // Before the first step the remainder takes the top numerator bits that
    // lie above the quotient range; they are below the divisor when clamping.
    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [RW-1:0] n_sx;
        logic [RW-1:0] n_sy;
        logic [RW-1:0] n_d;
        logic [RW-1:0] n_hx;
        logic [RW-1:0] n_hy;
        always_comb begin
            n_d  = {1'b0, r_den[k]};
            if (k == 0) begin
                n_hx = RW'(r_nx[k] >> Steps);
                n_hy = RW'(r_ny[k] >> Steps);
            end else begin
                n_hx = r_rx[k];
                n_hy = r_ry[k];
            end
            n_sx = {n_hx[RW-2:0], r_nx[k][Steps-1-k]};
            n_sy = {n_hy[RW-2:0], r_ny[k][Steps-1-k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
                if (n_sx >= n_d) begin
                    r_rx[k+1] <= n_sx - n_d;
                    r_nx[k+1] <= r_nx[k] | (NW'(1) << (Steps-1-k));
                end else begin
                    r_rx[k+1] <= n_sx;
                    r_nx[k+1] <= r_nx[k] & ~(NW'(1) << (Steps-1-k));
                end
                if (n_sy >= n_d) begin
                    r_ry[k+1] <= n_sy - n_d;
                    r_ny[k+1] <= r_ny[k] | (NW'(1) << (Steps-1-k));
                end else begin
                    r_ry[k+1] <= n_sy;
                    r_ny[k+1] <= r_ny[k] & ~(NW'(1) << (Steps-1-k));
                end
            end
        end
    end

    assign o_valid = r_vld[Steps];
    assign o_quo_x = r_nx[Steps][Steps-1:0];
    assign o_quo_y = r_ny[Steps][Steps-1:0];
    assign o_side  = r_side[Steps];
endmodule
`default_nettype wire

@@ sv/vector_magnitude_clamp_2d.sv @@
// Top level of the 2D vector length clamp.
// Accepts one vector beat per cycle while not stalled and returns one result beat per
// vector, in order. The stages are two product stages, a compare stage, a 17-stage
// square root, a 16-stage divider and an output register. The whole pipeline
// advances only when the output register is free or being emptied, so i_stall
// holds every stage.
`default_nettype none
module vector_magnitude_clamp_2d (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [14:0]           i_cfg_wdata,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire vmc_pkg::t_vec_in      i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output vmc_pkg::t_vec_out          o_data
);
    localparam int MW = vmc_pkg::MagWidth;
    localparam int LW = vmc_pkg::LenWidth;
    localparam int SW = vmc_pkg::SqWidth;

    logic [LW-1:0] r_limit;
    logic          n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '1;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign n_en    = !o_valid || !i_stall;
    assign o_stall = !n_en;

    // Stage 1: magnitudes and squares.
    logic              r1_vld;
    vmc_pkg::t_side    r1_side;
    logic [2*MW-1:0]   r1_xx;
    logic [2*MW-1:0]   r1_yy;
    logic [2*LW-1:0]   r1_mm;
    logic              n_nx;
    logic              n_ny;
    logic [MW-1:0]     n_ax;
    logic [MW-1:0]     n_ay;

    always_comb begin
        n_nx = i_data.vec_x[MW-1];
        n_ny = i_data.vec_y[MW-1];
        n_ax = n_nx ? MW'(-i_data.vec_x) : MW'(i_data.vec_x);
        n_ay = n_ny ? MW'(-i_data.vec_y) : MW'(i_data.vec_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (n_en) begin
            r1_vld <= i_valid;
        end
        if (n_en) begin
            r1_side.neg_x <= n_nx;
            r1_side.neg_y <= n_ny;
            r1_side.mag_x <= n_ax;
            r1_side.mag_y <= n_ay;
            r1_side.limit <= r_limit;
            r1_side.clamp <= 1'b0;
            r1_side.raw   <= i_data;
            r1_xx <= n_ax * n_ax;
            r1_yy <= n_ay * n_ay;
            r1_mm <= r_limit * r_limit;
        end
    end

    // Stage 2: sum and compare against the squared limit.
    logic              r2_vld;
    vmc_pkg::t_side    r2_side;
    logic [SW-1:0]     r2_sq;
    logic [SW-1:0]     n_sum;
    vmc_pkg::t_side    n_side;

    assign n_sum = SW'(r1_xx) + SW'(r1_yy);

    always_comb begin
        n_side       = r1_side;
        n_side.clamp = n_sum > SW'(r1_mm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (n_en) begin
            r2_vld <= r1_vld;
        end
        if (n_en) begin
            r2_sq   <= n_sum;
            r2_side <= n_side;
        end
    end

    // Square root of the squared length.
    logic                           s_vld;
    logic [vmc_pkg::RootWidth-1:0]  s_root;
    vmc_pkg::t_side                 s_side;

    vmc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (r2_vld),
        .i_sq    (r2_sq),
        .i_side  (r2_side),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // Stage 3: scaled numerators; an unclamped item gets divisor one to stay harmless.
    logic                             r3_vld;
    vmc_pkg::t_side                   r3_side;
    logic [vmc_pkg::ProdWidth-1:0]    r3_px;
    logic [vmc_pkg::ProdWidth-1:0]    r3_py;
    logic [vmc_pkg::RootWidth-1:0]    r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (n_en) begin
            r3_vld <= s_vld;
        end
        if (n_en) begin
            r3_side <= s_side;
            r3_px   <= s_side.mag_x * s_side.limit;
            r3_py   <= s_side.mag_y * s_side.limit;
            r3_den  <= s_side.clamp ? s_root : vmc_pkg::RootWidth'(1);
        end
    end

    logic              d_vld;
    logic [MW-1:0]     d_qx;
    logic [MW-1:0]     d_qy;
    vmc_pkg::t_side    d_side;

    vmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (r3_vld),
        .i_num_x (r3_px),
        .i_num_y (r3_py),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_valid (d_vld),
        .o_quo_x (d_qx),
        .o_quo_y (d_qy),
        .o_side  (d_side)
    );

    // Output register.
    logic              r_ovld;
    vmc_pkg::t_vec_out r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (n_en) begin
            r_ovld <= d_vld;
        end
        if (n_en) begin
            if (d_side.clamp) begin
                r_odata.out_x <= d_side.neg_x ? -d_qx : d_qx;
                r_odata.out_y <= d_side.neg_y ? -d_qy : d_qy;
            end else begin
                r_odata.out_x <= d_side.raw.vec_x;
                r_odata.out_y <= d_side.raw.vec_y;
            end
            r_odata.clamped <= d_side.clamp;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_odata;
endmodule
`default_nettype wire

@@ bench/vmc_checker.sv @@
// Checker for the 2D vector length clamp: predicts each result and compares it.
module vmc_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [14:0]       i_cfg_wdata,
    input  wire logic              i_valid,
    input  wire logic              i_in_stall,
    input  wire vmc_pkg::t_vec_in  i_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_stall,
    input  wire vmc_pkg::t_vec_out i_out_data,
    output int                     o_errors,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = vmc_pkg::DataWidth;

    logic [vmc_pkg::LenWidth-1:0] limit_q;
    vmc_pkg::t_vec_out            expected_q[$];

    // Ceiling of the square root, found bit by bit from the top.
    function automatic longint unsigned root_ceil(longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 17; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) begin
                r = r | (64'd1 << b);
            end
        end
        if (r * r < v) begin
            r = r + 1;
        end
        return r;
    endfunction

    function automatic vmc_pkg::t_vec_out clamp_vector(vmc_pkg::t_vec_in v,
                                                       logic [vmc_pkg::LenWidth-1:0] lim);
        vmc_pkg::t_vec_out res;
        longint unsigned   ax, ay, m, sq, len, qx, qy;
        ax = (v.vec_x < 0) ? longint'(-longint'(v.vec_x)) : longint'(v.vec_x);
        ay = (v.vec_y < 0) ? longint'(-longint'(v.vec_y)) : longint'(v.vec_y);
        m  = lim;
        sq = ax * ax + ay * ay;
        if (sq > m * m) begin
            len = root_ceil(sq);
            qx  = (ax * m) / len;
            qy  = (ay * m) / len;
            res.out_x   = (v.vec_x < 0) ? -DW'(qx) : DW'(qx);
            res.out_y   = (v.vec_y < 0) ? -DW'(qy) : DW'(qy);
            res.clamped = 1'b1;
        end else begin
            res.out_x   = v.vec_x;
            res.out_y   = v.vec_y;
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        vmc_pkg::t_vec_out want;
        if (!i_rst_n) begin
            limit_q  <= '1;
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                limit_q <= i_cfg_wdata;
            end
            if (i_valid && !i_in_stall) begin
                expected_q.push_back(clamp_vector(i_data, limit_q));
            end
            if (i_out_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("unexpected result beat %p", i_out_data);
                    end
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.out_x !== i_out_data.out_x || want.out_y !== i_out_data.out_y
                            || want.clamped !== i_out_data.clamped) begin
                        if (o_errors < 10) begin
                            $display({"mismatch: expected x=%0d y=%0d c=%0b,",
                                      " got x=%0d y=%0d c=%0b"},
                                want.out_x, want.out_y, want.clamped,
                                i_out_data.out_x, i_out_data.out_y,
                                i_out_data.clamped);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/tb.sv @@
// Stimulus and verdict for the 2D vector length clamp.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency   = 37;
    localparam int IdleLimit = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [14:0]       cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    vmc_pkg::t_vec_in  in_data;
    logic              out_valid;
    logic              out_stall;
    vmc_pkg::t_vec_out out_data;
    int                errors;
    int                pending;
    int                idle_cycles;

    vector_magnitude_clamp_2d i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data)
    );

    vmc_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .i_in_stall(in_stall), .i_data(in_data),
        .i_out_valid(out_valid), .i_stall(out_stall), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(10, 40);
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Watchdog: cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("vector_magnitude_clamp_2d test failed");
                $finish;
            end
        end
    end

    // Output stall pattern with quiet stretches.
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            n = gap_length();
            if ($urandom_range(0, 3) == 0) begin
                n = 0;
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
            end
            repeat (n) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
            end
            @(negedge i_clk);
            out_stall <= 1'b0;
        end
    end

    task automatic send_vector(logic [15:0] x, logic [15:0] y);
        in_data.vec_x <= x;
        in_data.vec_y <= y;
        in_valid      <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        repeat (gap_length()) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (Latency + 5) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [14:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_vector(logic [14:0] lim);
        logic [15:0] x, y;
        int          k;
        k = $urandom_range(0, 9);
        x = 16'($urandom);
        y = 16'($urandom);
        // Half of the vectors are kept near the limit so the compare is exercised.
        if (k < 5) begin
            x = 16'($urandom_range(0, lim + 2) * (($urandom_range(0, 1) != 0) ? 1 : -1));
            y = 16'($urandom_range(0, lim + 2) * (($urandom_range(0, 1) != 0) ? 1 : -1));
        end else if (k == 5) begin
            x = 16'h8000;
        end
        send_vector(x, y);
    endtask

    initial begin
        logic [14:0] limits[6];
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed vectors at the reset limit: extremes and the boundary.
        send_vector(16'h0000, 16'h0000);
        send_vector(16'h7fff, 16'h0000);
        send_vector(16'h8000, 16'h0000);
        send_vector(16'h0000, 16'h8000);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7fff, 16'h7fff);
        send_vector(16'h8001, 16'h0001);
        send_vector(16'hffff, 16'hffff);
        drain_pipeline();

        // A zero limit clamps every nonzero vector to the origin.
        write_limit('0);
        send_vector(16'h0000, 16'h0000);
        send_vector(16'h0001, 16'h0000);
        send_vector(16'hffff, 16'h8000);
        drain_pipeline();

        // A 3-4-5 triangle lands exactly on the limit and passes unchanged.
        write_limit(15'd5);
        send_vector(16'd3, 16'd4);
        send_vector(-16'sd3, -16'sd4);
        send_vector(16'd3, 16'd5);
        send_vector(16'd5, 16'd0);
        send_vector(16'd6, 16'd0);
        drain_pipeline();

        limits = '{15'h7fff, 15'd0, 15'd1, 15'd256, 15'd5000, 15'h4000};
        for (int p = 0; p < 8; p++) begin
            logic [14:0] lim;
            lim = (p < 6) ? limits[p] : 15'($urandom);
            write_limit(lim);
            repeat (100) random_vector(lim);
            drain_pipeline();
        end

        if (errors == 0) begin
            $display("vector_magnitude_clamp_2d test passed");
        end else begin
            $display("vector_magnitude_clamp_2d test failed");
        end
        $finish;
    end
endmodule
